// ----- src/apt_pkg.sv -----
`default_nettype none
// ============================================================================
// apt_pkg: shared types and codes for the alarm priority table
// Holds the table entry layout, the status, command and result codes.
// ============================================================================
package apt_pkg;

    // One table entry as it sits in the entry memory.
    typedef struct packed {
        logic [7:0] id;
        logic [1:0] status;
        logic [1:0] prio;
    } t_entry;

    // Alarm status codes.
    localparam logic [1:0] ST_INACTIVE = 2'd0;
    localparam logic [1:0] ST_PAUSED   = 2'd1;
    localparam logic [1:0] ST_WAITING  = 2'd2;
    localparam logic [1:0] ST_ACTIVE   = 2'd3;

    // Command codes.
    localparam logic [1:0] FN_UPDATE = 2'd0;
    localparam logic [1:0] FN_ARB    = 2'd1;
    localparam logic [1:0] FN_READ   = 2'd2;
    localparam logic [1:0] FN_NOP    = 2'd3;

    // Result codes.
    localparam logic [2:0] RC_OK          = 3'd0;
    localparam logic [2:0] RC_EMPTY       = 3'd1;
    localparam logic [2:0] RC_NOT_FOUND   = 3'd2;
    localparam logic [2:0] RC_BAD_INDEX   = 3'd3;
    localparam logic [2:0] RC_FULL        = 3'd4;
    localparam logic [2:0] RC_NONE_ACTIVE = 3'd5;

endpackage
`default_nettype wire

// ----- src/alarm_priority_table.sv -----
`default_nettype none
// ============================================================================
// alarm_priority_table: ordered table of alarms with arbitration
// Update, remove, arbitrate and read commands over a table of unique ids.
// ============================================================================
// Usage notes.
// The input channel (i_in_valid / o_in_stall) carries one command word:
// update or remove an alarm, arbitrate, read an entry, or no operation.
// The output channel (o_out_valid / i_out_stall) returns exactly one result
// word per command, in command order.
// The table lives in a single-port-read, single-port-write memory, and one
// sequencer walks it one entry per cycle with a single compare unit. Every
// command ends with a scan for the lowest active entry. Arbitration is the
// longest command (rank scan, demote scan, active scan); updates and removals,
// shift-down included, walk the table fewer times. The result word becomes
// valid in the same cycle as the block can take its next command.
// The block takes one command at a time: o_in_stall is high from the cycle
// after acceptance until the result is loaded into the output register.
// A finished result waits in that register while the next command may
// already be accepted; a held result blocks only the completion of the next.
// Reset empties the table at once (the count goes to zero); no clearing
// pass is needed, since entries at or beyond the count are never read.
// ============================================================================
module alarm_priority_table #(
    parameter int LIST_DEPTH = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // command channel
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [1:0]  i_func,
    input  wire logic [7:0]  i_alarm_id,
    input  wire logic [1:0]  i_new_status,
    input  wire logic [1:0]  i_new_priority,
    input  wire logic [3:0]  i_read_index,
    // result channel
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [2:0]       o_result_code,
    output logic [4:0]       o_entry_count,
    output logic             o_active_found,
    output logic [3:0]       o_active_index,
    output logic [7:0]       o_read_id,
    output logic [1:0]       o_read_status,
    output logic [1:0]       o_read_priority,
    output logic             o_log_valid,
    output logic [7:0]       o_log_id,
    output logic [1:0]       o_log_status,
    output logic [1:0]       o_log_priority
);
    import apt_pkg::*;

    // Count width holds 0..LIST_DEPTH, index width addresses the memory.
    localparam int CW   = $clog2(LIST_DEPTH + 1);
    localparam int IW   = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int CMPW = (CW > 4) ? CW : 4;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_POST = 3'b100
    } t_state;

    // What the current memory walk is doing.
    typedef enum logic [5:0] {
        M_FIND   = 6'b000001,
        M_SHIFT  = 6'b000010,
        M_ARB    = 6'b000100,
        M_DEMOTE = 6'b001000,
        M_READ   = 6'b010000,
        M_ACT    = 6'b100000
    } t_mode;

    t_state r_state, n_state;
    t_mode  r_mode,  n_mode;

    logic [CW-1:0] r_ptr,    n_ptr;
    logic          r_rd_vld, n_rd_vld;
    logic [IW-1:0] r_ridx,   n_ridx;
    logic [CW-1:0] r_cnt,    n_cnt;

    // command held for the duration of the walk
    logic [7:0]    r_id,     n_id;
    logic [1:0]    r_st,     n_st;
    logic [1:0]    r_pr,     n_pr;
    logic          r_remove, n_remove;

    // result under construction
    logic [2:0]    r_rc,  n_rc;
    logic [7:0]    r_rid, n_rid;
    logic [1:0]    r_rst, n_rst;
    logic [1:0]    r_rpr, n_rpr;
    logic          r_lv,  n_lv;
    logic [7:0]    r_lid, n_lid;
    logic [1:0]    r_lst, n_lst;
    logic [1:0]    r_lpr, n_lpr;
    logic          r_af,  n_af;
    logic [IW-1:0] r_ai,  n_ai;

    // arbitration best-so-far
    logic          r_have, n_have;
    logic [IW-1:0] r_best, n_best;
    logic [1:0]    r_bs,   n_bs;
    logic [1:0]    r_bp,   n_bp;

    // memory port
    logic          w_we;
    logic [IW-1:0] w_waddr;
    t_entry        w_wdata;
    t_entry        w_rdata;

    logic w_accept;
    logic w_issue;
    logic w_scan_end;
    logic w_better;
    logic w_out_free;
    logic w_go_act;
    logic w_go_post;

    apt_table #(
        .DEPTH (LIST_DEPTH),
        .AW    (IW)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (r_ptr[IW-1:0]),
        .o_rdata (w_rdata)
    );

    apt_rank u_rank (
        .i_cand        (w_rdata),
        .i_have        (r_have),
        .i_best_status (r_bs),
        .i_best_prio   (r_bp),
        .o_better      (w_better)
    );

    assign o_in_stall = (r_state != S_IDLE);
    assign w_accept   = i_in_valid && (r_state == S_IDLE);
    assign w_out_free = !o_out_valid || !i_out_stall;

    // A read is issued at r_ptr while entries remain; its data comes back
    // in the following cycle, tagged with r_ridx.
    assign w_issue    = (r_ptr < r_cnt);
    assign w_scan_end = !w_issue && !r_rd_vld;

    always_comb begin
        n_state  = r_state;
        n_mode   = r_mode;
        n_ptr    = r_ptr;
        n_rd_vld = 1'b0;
        n_ridx   = r_ridx;
        n_cnt    = r_cnt;
        n_id     = r_id;
        n_st     = r_st;
        n_pr     = r_pr;
        n_remove = r_remove;
        n_rc     = r_rc;
        n_rid    = r_rid;
        n_rst    = r_rst;
        n_rpr    = r_rpr;
        n_lv     = r_lv;
        n_lid    = r_lid;
        n_lst    = r_lst;
        n_lpr    = r_lpr;
        n_af     = r_af;
        n_ai     = r_ai;
        n_have   = r_have;
        n_best   = r_best;
        n_bs     = r_bs;
        n_bp     = r_bp;
        w_we     = 1'b0;
        w_waddr  = r_ridx;
        w_wdata  = w_rdata;
        w_go_act  = 1'b0;
        w_go_post = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state  = S_SCAN;
                    n_id     = i_alarm_id;
                    n_pr     = i_new_priority;
                    n_st     = (i_new_status == ST_ACTIVE) ? ST_WAITING : i_new_status;
                    n_remove = (i_new_status == ST_INACTIVE);
                    n_rc     = RC_OK;
                    n_rid    = '0;
                    n_rst    = '0;
                    n_rpr    = '0;
                    n_lv     = 1'b0;
                    n_lid    = '0;
                    n_lst    = '0;
                    n_lpr    = '0;
                    n_have   = 1'b0;
                    n_ptr    = '0;
                    case (i_func)
                        FN_UPDATE: begin
                            if (i_new_status == ST_INACTIVE) begin
                                // A removal is logged whether or not it hits.
                                n_lv  = 1'b1;
                                n_lid = i_alarm_id;
                                n_lst = ST_INACTIVE;
                                n_lpr = i_new_priority;
                            end
                            if ((i_new_status == ST_INACTIVE) && (r_cnt == '0)) begin
                                n_rc     = RC_EMPTY;
                                w_go_act = 1'b1;
                            end else begin
                                n_mode = M_FIND;
                            end
                        end
                        FN_ARB: begin
                            if (r_cnt == '0) begin
                                n_rc     = RC_EMPTY;
                                w_go_act = 1'b1;
                            end else begin
                                n_mode = M_ARB;
                            end
                        end
                        FN_READ: begin
                            if (CMPW'(i_read_index) >= CMPW'(r_cnt)) begin
                                n_rc     = RC_BAD_INDEX;
                                w_go_act = 1'b1;
                            end else begin
                                n_mode = M_READ;
                                n_ptr  = CW'(i_read_index);
                            end
                        end
                        default: begin
                            w_go_act = 1'b1;
                        end
                    endcase
                end
            end

            S_SCAN: begin
                if (w_issue) begin
                    n_ptr    = r_ptr + 1'b1;
                    n_rd_vld = 1'b1;
                    n_ridx   = r_ptr[IW-1:0];
                end
                unique case (r_mode)
                    M_FIND: begin
                        if (r_rd_vld && (w_rdata.id == r_id)) begin
                            if (r_remove) begin
                                // Pull every later entry down by one.
                                n_mode   = M_SHIFT;
                                n_ptr    = CW'(r_ridx) + 1'b1;
                                n_rd_vld = 1'b0;
                            end else begin
                                w_we    = 1'b1;
                                w_waddr = r_ridx;
                                w_wdata = '{id: r_id, status: r_st, prio: r_pr};
                                if (w_rdata.status != r_st) begin
                                    n_lv  = 1'b1;
                                    n_lid = r_id;
                                    n_lst = r_st;
                                    n_lpr = r_pr;
                                end
                                w_go_act = 1'b1;
                            end
                        end else if (w_scan_end) begin
                            if (r_remove) begin
                                n_rc = RC_NOT_FOUND;
                            end else if (r_cnt < CW'(LIST_DEPTH)) begin
                                w_we    = 1'b1;
                                w_waddr = r_cnt[IW-1:0];
                                w_wdata = '{id: r_id, status: r_st, prio: r_pr};
                                n_cnt   = r_cnt + 1'b1;
                                n_lv    = 1'b1;
                                n_lid   = r_id;
                                n_lst   = r_st;
                                n_lpr   = r_pr;
                            end else begin
                                n_rc = RC_FULL;
                            end
                            w_go_act = 1'b1;
                        end
                    end
                    M_SHIFT: begin
                        if (r_rd_vld) begin
                            w_we    = 1'b1;
                            w_waddr = r_ridx - 1'b1;
                            w_wdata = w_rdata;
                        end
                        if (w_scan_end) begin
                            n_cnt    = r_cnt - 1'b1;
                            w_go_act = 1'b1;
                        end
                    end
                    M_ARB: begin
                        if (r_rd_vld && w_better) begin
                            n_have = 1'b1;
                            n_best = r_ridx;
                            n_bs   = w_rdata.status;
                            n_bp   = w_rdata.prio;
                        end
                        if (w_scan_end) begin
                            if (r_have) begin
                                n_mode   = M_DEMOTE;
                                n_ptr    = '0;
                                n_rd_vld = 1'b0;
                            end else begin
                                n_rc     = RC_NONE_ACTIVE;
                                w_go_act = 1'b1;
                            end
                        end
                    end
                    M_DEMOTE: begin
                        // The winner becomes active, every other active waits.
                        if (r_rd_vld) begin
                            w_we    = 1'b1;
                            w_waddr = r_ridx;
                            w_wdata = w_rdata;
                            if (r_ridx == r_best) begin
                                w_wdata.status = ST_ACTIVE;
                            end else if (w_rdata.status == ST_ACTIVE) begin
                                w_wdata.status = ST_WAITING;
                            end
                        end
                        if (w_scan_end) begin
                            w_go_act = 1'b1;
                        end
                    end
                    M_READ: begin
                        if (r_rd_vld) begin
                            n_rid    = w_rdata.id;
                            n_rst    = w_rdata.status;
                            n_rpr    = w_rdata.prio;
                            w_go_act = 1'b1;
                        end else if (w_scan_end) begin
                            w_go_act = 1'b1;
                        end
                    end
                    M_ACT: begin
                        if (r_rd_vld && (w_rdata.status == ST_ACTIVE)) begin
                            n_af      = 1'b1;
                            n_ai      = r_ridx;
                            w_go_post = 1'b1;
                        end else if (w_scan_end) begin
                            w_go_post = 1'b1;
                        end
                    end
                    default: begin
                        w_go_post = 1'b1;
                    end
                endcase
            end

            S_POST: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Every command closes with a walk for the lowest active entry.
        if (w_go_act) begin
            n_mode   = M_ACT;
            n_ptr    = '0;
            n_rd_vld = 1'b0;
            n_af     = 1'b0;
            n_ai     = '0;
        end
        if (w_go_post) begin
            n_state  = S_POST;
            n_rd_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mode      <= M_ACT;
            r_ptr       <= '0;
            r_rd_vld    <= 1'b0;
            r_cnt       <= '0;
            o_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_mode   <= n_mode;
            r_ptr    <= n_ptr;
            r_rd_vld <= n_rd_vld;
            r_cnt    <= n_cnt;
            if ((r_state == S_POST) && w_out_free) begin
                o_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                o_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ridx   <= n_ridx;
        r_id     <= n_id;
        r_st     <= n_st;
        r_pr     <= n_pr;
        r_remove <= n_remove;
        r_rc     <= n_rc;
        r_rid    <= n_rid;
        r_rst    <= n_rst;
        r_rpr    <= n_rpr;
        r_lv     <= n_lv;
        r_lid    <= n_lid;
        r_lst    <= n_lst;
        r_lpr    <= n_lpr;
        r_af     <= n_af;
        r_ai     <= n_ai;
        r_have   <= n_have;
        r_best   <= n_best;
        r_bs     <= n_bs;
        r_bp     <= n_bp;
    end

    // Output word register, loaded once the result is complete and the
    // previous word has been taken.
    always_ff @(posedge i_clk) begin
        if ((r_state == S_POST) && w_out_free) begin
            o_result_code   <= r_rc;
            o_entry_count   <= 5'(r_cnt);
            o_active_found  <= r_af;
            o_active_index  <= 4'(r_ai);
            o_read_id       <= r_rid;
            o_read_status   <= r_rst;
            o_read_priority <= r_rpr;
            o_log_valid     <= r_lv;
            o_log_id        <= r_lid;
            o_log_status    <= r_lst;
            o_log_priority  <= r_lpr;
        end
    end

endmodule
`default_nettype wire

// ----- src/apt_table.sv -----
`default_nettype none
// ============================================================================
// apt_table: entry memory of the alarm priority table
// One write port and one read port with registered read data.
// ============================================================================
module apt_table #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  wire logic            i_clk,
    input  wire logic            i_we,
    input  wire logic [AW-1:0]   i_waddr,
    input  wire apt_pkg::t_entry i_wdata,
    input  wire logic [AW-1:0]   i_raddr,
    output apt_pkg::t_entry      o_rdata
);
    import apt_pkg::*;

    t_entry r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

// ----- src/apt_rank.sv -----
`default_nettype none
// ============================================================================
// apt_rank: arbitration compare unit
// Tells whether a candidate entry beats the best entry found so far.
// ============================================================================
module apt_rank (
    input  wire apt_pkg::t_entry i_cand,
    input  wire logic         i_have,
    input  wire logic [1:0]   i_best_status,
    input  wire logic [1:0]   i_best_prio,
    output logic              o_better
);
    import apt_pkg::*;

    logic w_elig;

    // Only active or waiting entries compete. Strict compares keep the
    // earlier entry on a full tie.
    assign w_elig   = (i_cand.status == ST_ACTIVE) || (i_cand.status == ST_WAITING);
    assign o_better = w_elig && (!i_have || (i_cand.prio > i_best_prio) ||
                      ((i_cand.prio == i_best_prio) && (i_cand.status > i_best_status)));

endmodule
`default_nettype wire

// ----- tb/alarm_priority_table_tb.sv -----
// ============================================================================
// alarm_priority_table_tb: self-checking bench for the alarm priority table
// A directed pass walks through every command and each corner of the table
// logic. Random traffic then fills, churns and drains the table under three
// idling patterns. A shadow copy of the table in the bench predicts every
// result word, and each result word is compared field by field.
// ============================================================================
module alarm_priority_table_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import apt_pkg::*;

    localparam int DEPTH = 16;

    // Priority levels, as carried in the command and result words.
    localparam logic [1:0] PR_NONE = 2'd0;
    localparam logic [1:0] PR_LOW  = 2'd1;
    localparam logic [1:0] PR_MED  = 2'd2;
    localparam logic [1:0] PR_HIGH = 2'd3;

    // Kinds of random bursts. Each one biases toward adding or removing
    // alarms, so the table regularly runs full and regularly runs empty.
    localparam int BURST_FILL  = 0;
    localparam int BURST_CHURN = 1;
    localparam int BURST_DRAIN = 2;

    // Cycles with no word accepted on either channel before we give up.
    // The limit has to cover the slowest command plus the random gaps and
    // stalls on top of it.
    localparam int QUIET_LIMIT = 4000;
    // Cycles to keep watching after the last expected result, so that any
    // extra result word from the block still gets caught.
    localparam int TAIL_CYCLES = 2 * (3 * DEPTH + 8);

    typedef struct packed {
        logic [1:0] func;
        logic [7:0] id;
        logic [1:0] status;
        logic [1:0] prio;
        logic [3:0] idx;
    } t_cmd;

    typedef struct packed {
        logic [2:0] code;
        logic [4:0] count;
        logic       act_found;
        logic [3:0] act_idx;
        logic [7:0] rd_id;
        logic [1:0] rd_status;
        logic [1:0] rd_prio;
        logic       log_valid;
        logic [7:0] log_id;
        logic [1:0] log_status;
        logic [1:0] log_prio;
    } t_result;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_stall;
    logic [1:0] i_func;
    logic [7:0] i_alarm_id;
    logic [1:0] i_new_status;
    logic [1:0] i_new_priority;
    logic [3:0] i_read_index;
    logic       o_out_valid;
    logic       i_out_stall;
    logic [2:0] o_result_code;
    logic [4:0] o_entry_count;
    logic       o_active_found;
    logic [3:0] o_active_index;
    logic [7:0] o_read_id;
    logic [1:0] o_read_status;
    logic [1:0] o_read_priority;
    logic       o_log_valid;
    logic [7:0] o_log_id;
    logic [1:0] o_log_status;
    logic [1:0] o_log_priority;

    // Shadow copy of the table, updated as each command word is accepted.
    logic [7:0] shadow_id     [DEPTH];
    logic [1:0] shadow_status [DEPTH];
    logic [1:0] shadow_prio   [DEPTH];
    int         shadow_count;

    // Result words predicted but not yet seen, oldest first.
    t_result    expected_results [$];

    int send_idle_pct;
    int recv_stall_pct;
    int mismatch_count;
    int n_commands;
    int n_checked;
    int n_full;
    int n_arb_won;
    int n_removed;
    int quiet_cycles;

    alarm_priority_table #(
        .LIST_DEPTH(DEPTH)
    ) u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_func         (i_func),
        .i_alarm_id     (i_alarm_id),
        .i_new_status   (i_new_status),
        .i_new_priority (i_new_priority),
        .i_read_index   (i_read_index),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_result_code  (o_result_code),
        .o_entry_count  (o_entry_count),
        .o_active_found (o_active_found),
        .o_active_index (o_active_index),
        .o_read_id      (o_read_id),
        .o_read_status  (o_read_status),
        .o_read_priority(o_read_priority),
        .o_log_valid    (o_log_valid),
        .o_log_id       (o_log_id),
        .o_log_status   (o_log_status),
        .o_log_priority (o_log_priority)
    );

    // 4 ns clock.
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Table prediction
    // ------------------------------------------------------------------------

    // Position of an id in the shadow table, or -1 when it is not there.
    function automatic int shadow_lookup(input logic [7:0] id);
        for (int i = 0; i < shadow_count; i++) begin
            if (shadow_id[i] == id) begin
                return i;
            end
        end
        return -1;
    endfunction

    // Applies one command word to the shadow table and returns the result
    // word that the block must produce for it.
    function automatic t_result apply_alarm_command(input t_cmd c);
        t_result    r;
        int         pos;
        int         best;
        logic [1:0] stored;
        logic [1:0] best_prio;
        logic [1:0] best_status;

        r = '0;
        r.code = RC_OK;
        best_prio = PR_NONE;
        best_status = ST_INACTIVE;
        case (c.func)
            FN_UPDATE: begin
                if (c.status == ST_INACTIVE) begin
                    // A removal is always logged, even when it finds nothing.
                    r.log_valid = 1'b1;
                    r.log_id = c.id;
                    r.log_status = ST_INACTIVE;
                    r.log_prio = c.prio;
                    pos = shadow_lookup(c.id);
                    if (shadow_count == 0) begin
                        r.code = RC_EMPTY;
                    end else if (pos < 0) begin
                        r.code = RC_NOT_FOUND;
                    end else begin
                        // Close the gap: later entries move down by one.
                        for (int i = pos; i < shadow_count - 1; i++) begin
                            shadow_id[i] = shadow_id[i+1];
                            shadow_status[i] = shadow_status[i+1];
                            shadow_prio[i] = shadow_prio[i+1];
                        end
                        shadow_count--;
                    end
                end else begin
                    // Only arbitration may make an entry active.
                    stored = (c.status == ST_ACTIVE) ? ST_WAITING : c.status;
                    pos = shadow_lookup(c.id);
                    if (pos >= 0) begin
                        if (shadow_status[pos] != stored) begin
                            r.log_valid = 1'b1;
                            r.log_id = c.id;
                            r.log_status = stored;
                            r.log_prio = c.prio;
                        end
                        shadow_status[pos] = stored;
                        shadow_prio[pos] = c.prio;
                    end else if (shadow_count < DEPTH) begin
                        shadow_id[shadow_count] = c.id;
                        shadow_status[shadow_count] = stored;
                        shadow_prio[shadow_count] = c.prio;
                        shadow_count++;
                        r.log_valid = 1'b1;
                        r.log_id = c.id;
                        r.log_status = stored;
                        r.log_prio = c.prio;
                    end else begin
                        r.code = RC_FULL;
                    end
                end
            end
            FN_ARB: begin
                // Rank: higher priority first, then active over waiting,
                // then the lowest index, since only a strict win replaces.
                best = -1;
                for (int i = 0; i < shadow_count; i++) begin
                    if (shadow_status[i] == ST_ACTIVE || shadow_status[i] == ST_WAITING) begin
                        if (best < 0 || shadow_prio[i] > best_prio ||
                            (shadow_prio[i] == best_prio && shadow_status[i] > best_status)) begin
                            best = i;
                            best_prio = shadow_prio[i];
                            best_status = shadow_status[i];
                        end
                    end
                end
                if (shadow_count == 0) begin
                    r.code = RC_EMPTY;
                end else if (best < 0) begin
                    r.code = RC_NONE_ACTIVE;
                end else begin
                    for (int i = 0; i < shadow_count; i++) begin
                        if (i != best && shadow_status[i] == ST_ACTIVE) begin
                            shadow_status[i] = ST_WAITING;
                        end
                    end
                    shadow_status[best] = ST_ACTIVE;
                end
            end
            FN_READ: begin
                if (int'(c.idx) >= shadow_count) begin
                    r.code = RC_BAD_INDEX;
                end else begin
                    r.rd_id = shadow_id[c.idx];
                    r.rd_status = shadow_status[c.idx];
                    r.rd_prio = shadow_prio[c.idx];
                end
            end
            default: begin
            end
        endcase

        // Every result word reports the lowest active position.
        for (int i = 0; i < shadow_count; i++) begin
            if (shadow_status[i] == ST_ACTIVE && !r.act_found) begin
                r.act_found = 1'b1;
                r.act_idx = 4'(i);
            end
        end
        r.count = 5'(shadow_count);
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Command channel
    // ------------------------------------------------------------------------

    // Sends one command word and records its predicted result once the
    // block takes it. Valid is only lowered for an idle gap, so that a
    // back-to-back word never sees valid dropped and raised in one step.
    task automatic send_word(input logic [1:0] func, input logic [7:0] id,
                             input logic [1:0] status, input logic [1:0] prio,
                             input logic [3:0] idx);
        t_cmd    c;
        t_result want;

        c = {func, id, status, prio, idx};
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_func         <= func;
        i_alarm_id     <= id;
        i_new_status   <= status;
        i_new_priority <= prio;
        i_read_index   <= idx;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
        want = apply_alarm_command(c);
        expected_results.push_back(want);
        n_commands++;
        if (want.code == RC_FULL) begin
            n_full++;
        end
        if (func == FN_ARB && want.code == RC_OK) begin
            n_arb_won++;
        end
        if (func == FN_UPDATE && status == ST_INACTIVE && want.code == RC_OK) begin
            n_removed++;
        end
    endtask

    // Draws one random command word. Outside fill bursts most updates hit ids
    // already in the table so that overwrites, status changes and removals really
    // happen; the rest bring in new ids or miss the table entirely.
    function automatic t_cmd pick_command(input int burst);
        t_cmd c;
        int   roll;
        int   remove_pct;
        int   known_pct;

        c.func   = FN_UPDATE;
        c.id     = 8'($urandom_range(255));
        c.status = 2'($urandom_range(3));
        c.prio   = 2'($urandom_range(3));
        c.idx    = 4'($urandom_range(15));
        roll = $urandom_range(99);
        if (roll < 12) begin
            c.func = FN_ARB;
        end else if (roll < 30) begin
            c.func = FN_READ;
        end else if (roll < 34) begin
            c.func = FN_NOP;
        end

        remove_pct = (burst == BURST_FILL) ? 5 : (burst == BURST_DRAIN) ? 65 : 30;
        known_pct  = (burst == BURST_FILL) ? 25 : 70;
        if (c.func == FN_UPDATE) begin
            if ($urandom_range(99) < remove_pct) begin
                c.status = ST_INACTIVE;
            end else begin
                c.status = 2'($urandom_range(3, 1));
            end
            if (shadow_count > 0 && $urandom_range(99) < known_pct) begin
                c.id = shadow_id[$urandom_range(shadow_count - 1)];
            end
        end else if (c.func == FN_READ && shadow_count > 0 && $urandom_range(99) < 75) begin
            c.idx = 4'($urandom_range(shadow_count - 1));
        end
        return c;
    endfunction

    // ------------------------------------------------------------------------
    // Result channel: random stall and the field-by-field check
    // ------------------------------------------------------------------------

    task check_field(input string what, input int want, input int got);
        if (want != got) begin
            mismatch_count++;
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
        end
    endtask

    always @(posedge i_clk) begin : result_check
        t_result want;

        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_results.size() == 0) begin
                mismatch_count++;
                $display("%0t ns: result word with no command pending, expected none, actual code %0d",
                         $time, o_result_code);
            end else begin
                want = expected_results.pop_front();
                n_checked++;
                check_field("result_code",   int'(want.code),       int'(o_result_code));
                check_field("entry_count",   int'(want.count),      int'(o_entry_count));
                check_field("active_found",  int'(want.act_found),  int'(o_active_found));
                check_field("active_index",  int'(want.act_idx),    int'(o_active_index));
                check_field("read_id",       int'(want.rd_id),      int'(o_read_id));
                check_field("read_status",   int'(want.rd_status),  int'(o_read_status));
                check_field("read_priority", int'(want.rd_prio),    int'(o_read_priority));
                check_field("log_valid",     int'(want.log_valid),  int'(o_log_valid));
                check_field("log_id",        int'(want.log_id),     int'(o_log_id));
                check_field("log_status",    int'(want.log_status), int'(o_log_status));
                check_field("log_priority",  int'(want.log_prio),   int'(o_log_priority));
            end
        end
        i_out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // The watchdog restarts whenever a word moves on either channel.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t ns: no word moved for %0d cycles, %0d results outstanding",
                     $time, QUIET_LIMIT, expected_results.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Walks through each command and each corner of the table logic on a
    // table that starts empty.
    task automatic test_basic_commands();
        send_idle_pct  = 10;
        recv_stall_pct = 45;
        // Everything on an empty table: removal is still logged.
        send_word(FN_UPDATE, 8'hFF, ST_INACTIVE, PR_HIGH, 4'd0);
        send_word(FN_ARB,    8'h00, ST_INACTIVE, PR_NONE, 4'd0);
        send_word(FN_READ,   8'h00, ST_INACTIVE, PR_NONE, 4'd0);
        // The spare command code does nothing, even with every field high.
        send_word(FN_NOP,    8'hFF, ST_ACTIVE,   PR_HIGH, 4'hF);
        // Three new alarms; an active request is stored as waiting.
        send_word(FN_UPDATE, 8'h00, ST_PAUSED,   PR_NONE, 4'd0);
        send_word(FN_UPDATE, 8'hFF, ST_ACTIVE,   PR_HIGH, 4'd0);
        send_word(FN_UPDATE, 8'h5A, ST_WAITING,  PR_MED,  4'd0);
        // Overwrite with the same status (no log), then with a new status.
        send_word(FN_UPDATE, 8'h00, ST_PAUSED,   PR_HIGH, 4'd0);
        send_word(FN_UPDATE, 8'hFF, ST_PAUSED,   PR_HIGH, 4'd0);
        // Only one waiting entry, so it becomes active.
        send_word(FN_ARB,    8'h00, ST_INACTIVE, PR_NONE, 4'd0);
        // A waiting entry of higher priority takes over and the old active
        // entry is demoted.
        send_word(FN_UPDATE, 8'h00, ST_WAITING,  PR_HIGH, 4'd0);
        send_word(FN_ARB,    8'h00, ST_INACTIVE, PR_NONE, 4'd0);
        // Equal priority: the active entry keeps its place over a waiting one.
        send_word(FN_UPDATE, 8'hFF, ST_ACTIVE,   PR_HIGH, 4'd0);
        send_word(FN_ARB,    8'h00, ST_INACTIVE, PR_NONE, 4'd0);
        // Reads in range, and one at the top of the index field.
        send_word(FN_READ,   8'h00, ST_INACTIVE, PR_NONE, 4'd0);
        send_word(FN_READ,   8'h00, ST_INACTIVE, PR_NONE, 4'd2);
        send_word(FN_READ,   8'h00, ST_INACTIVE, PR_NONE, 4'hF);
        // Removal of an unknown id, then of the first entry with shift-down.
        send_word(FN_UPDATE, 8'h33, ST_INACTIVE, PR_LOW,  4'd0);
        send_word(FN_UPDATE, 8'h00, ST_INACTIVE, PR_MED,  4'd0);
        // Nothing active or waiting left for arbitration.
        send_word(FN_UPDATE, 8'hFF, ST_PAUSED,   PR_NONE, 4'd0);
        send_word(FN_UPDATE, 8'h5A, ST_PAUSED,   PR_LOW,  4'd0);
        send_word(FN_ARB,    8'h00, ST_INACTIVE, PR_NONE, 4'd0);
        send_word(FN_READ,   8'h00, ST_INACTIVE, PR_NONE, 4'd1);
    endtask

    // Random bursts of commands under the given idling pattern.
    task automatic test_mixed_traffic(input int n_words, input int send_pct, input int recv_pct);
        int   sent;
        int   burst;
        int   burst_len;
        t_cmd c;

        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        sent = 0;
        while (sent < n_words) begin
            burst = $urandom_range(BURST_DRAIN, BURST_FILL);
            burst_len = $urandom_range(50, 15);
            for (int k = 0; k < burst_len && sent < n_words; k++) begin
                c = pick_command(burst);
                send_word(c.func, c.id, c.status, c.prio, c.idx);
                sent++;
            end
        end
    endtask

    initial begin
        i_clk          = 1'b0;
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_func         = FN_NOP;
        i_alarm_id     = '0;
        i_new_status   = ST_INACTIVE;
        i_new_priority = PR_NONE;
        i_read_index   = '0;
        i_out_stall    = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        mismatch_count = 0;
        n_commands     = 0;
        n_checked      = 0;
        n_full         = 0;
        n_arb_won      = 0;
        n_removed      = 0;
        quiet_cycles   = 0;
        shadow_count   = 0;
        for (int i = 0; i < DEPTH; i++) begin
            shadow_id[i]     = '0;
            shadow_status[i] = ST_INACTIVE;
            shadow_prio[i]   = PR_NONE;
        end

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_basic_commands();
        // Fast sender, busy receiver; then the reverse; then full speed.
        test_mixed_traffic(480, 10, 45);
        test_mixed_traffic(480, 45, 10);
        test_mixed_traffic(490, 0, 0);

        i_in_valid <= 1'b0;
        while (expected_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Sent %0d commands and checked %0d result words.", n_commands, n_checked);
        $display("Full-table refusals: %0d, successful removals: %0d, arbitration wins: %0d.",
                 n_full, n_removed, n_arb_won);
        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
